// ===== sv/rrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types, widths and constants for the rotated rectangle corner block.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int CORDIC_STAGES = 16;   // 8 .. 24
  localparam int XW  = 33;             // CORDIC x/y, Q2.30 plus headroom
  localparam int ZW  = 28;             // residual angle, 2^-20 degree
  localparam int CSW = 17;             // sine/cosine, Q1.15 with +1.0
  localparam int PW  = 33;             // width x trig product
  localparam int VW  = 36;             // corner position, 2^-16 units
  localparam int IW  = 5;              // atan table index

  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic signed [13:0] ROT_ZERO   = 14'sd0;
  localparam logic signed [13:0] ROT_P90    = 14'sd1440;
  localparam logic signed [13:0] ROT_M90    = -14'sd1440;
  localparam logic signed [13:0] ROT_P180   = 14'sd2880;
  localparam logic signed [13:0] ROT_M180   = -14'sd2880;
  localparam logic signed [13:0] ROT_P270   = 14'sd4320;
  localparam logic signed [13:0] ROT_M270   = -14'sd4320;

  typedef enum logic [2:0] {
    ORD_IDENT,   // V1 V2 V3 V4
    ORD_CW,      // V3 V1 V4 V2
    ORD_HALF,    // V4 V3 V2 V1
    ORD_CCW,     // V2 V4 V1 V3
    ORD_SORT     // xmin ymin ymax xmax
  } ord_t;

  typedef struct packed {
    logic [14:0]        w;
    logic [14:0]        h;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    ord_t               ord;
    logic [1:0]         quad;
    logic               fzero;
  } box_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    box_t                 box;
  } cord_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [IW-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 28'sd47185920;
      5'd1:  v = 28'sd27855475;
      5'd2:  v = 28'sd14718068;
      5'd3:  v = 28'sd7471121;
      5'd4:  v = 28'sd3750058;
      5'd5:  v = 28'sd1876857;
      5'd6:  v = 28'sd938658;
      5'd7:  v = 28'sd469357;
      5'd8:  v = 28'sd234682;
      5'd9:  v = 28'sd117342;
      5'd10: v = 28'sd58671;
      5'd11: v = 28'sd29335;
      5'd12: v = 28'sd14668;
      5'd13: v = 28'sd7334;
      5'd14: v = 28'sd3667;
      5'd15: v = 28'sd1833;
      5'd16: v = 28'sd917;
      5'd17: v = 28'sd458;
      5'd18: v = 28'sd229;
      5'd19: v = 28'sd115;
      5'd20: v = 28'sd57;
      5'd21: v = 28'sd29;
      5'd22: v = 28'sd14;
      5'd23: v = 28'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/rrc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_in_if
// Box description channel: valid/ready plus box geometry.
// ----------------------------------------------------------------------------
interface rrc_in_if;
  logic               valid;
  logic               ready;
  logic [14:0]        box_width;
  logic [14:0]        box_height;
  logic signed [13:0] rotation;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;

  modport source (output valid, box_width, box_height, rotation, center_x, center_y,
                  input ready);
  modport sink   (input valid, box_width, box_height, rotation, center_x, center_y,
                  output ready);
endinterface

// ===== sv/rrc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_out_if
// Corner result channel: valid/ready plus four corners and clip flag.
// ----------------------------------------------------------------------------
interface rrc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] corner0_x;
  logic signed [15:0] corner0_y;
  logic signed [15:0] corner1_x;
  logic signed [15:0] corner1_y;
  logic signed [15:0] corner2_x;
  logic signed [15:0] corner2_y;
  logic signed [15:0] corner3_x;
  logic signed [15:0] corner3_y;
  logic               clipped;

  modport source (output valid, corner0_x, corner0_y, corner1_x, corner1_y,
                  corner2_x, corner2_y, corner3_x, corner3_y, clipped,
                  input ready);
  modport sink   (input valid, corner0_x, corner0_y, corner1_x, corner1_y,
                  corner2_x, corner2_y, corner3_x, corner3_y, clipped,
                  output ready);
endinterface

// ===== sv/rrc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_cell
// One CORDIC rotation step with its own valid/ready stage register.
// ----------------------------------------------------------------------------
module rrc_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [rrc_pkg::IW-1:0] stage_idx,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rrc_pkg::cord_t       in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rrc_pkg::cord_t       out_data
);

  logic           v_r;
  rrc_pkg::cord_t d_r;
  rrc_pkg::cord_t d_nxt;
  logic signed [rrc_pkg::XW-1:0] xs;
  logic signed [rrc_pkg::XW-1:0] ys;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    xs    = in_data.x >>> stage_idx;
    ys    = in_data.y >>> stage_idx;
    d_nxt = in_data;
    if (!in_data.z[rrc_pkg::ZW-1]) begin
      d_nxt.x = in_data.x - ys;
      d_nxt.y = in_data.y + xs;
      d_nxt.z = in_data.z - rrc_pkg::atan_lut(stage_idx);
    end else begin
      d_nxt.x = in_data.x + ys;
      d_nxt.y = in_data.y - xs;
      d_nxt.z = in_data.z + rrc_pkg::atan_lut(stage_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

// ===== sv/rrc_corner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrc_corner
// Sine/cosine finish, products, corner sums, ordering and saturation.
// ----------------------------------------------------------------------------
module rrc_corner (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rrc_pkg::cord_t  in_data,
  rrc_out_if.source       out_box
);

  localparam int CSW = rrc_pkg::CSW;
  localparam int PW  = rrc_pkg::PW;
  localparam int VW  = rrc_pkg::VW;
  localparam int XW  = rrc_pkg::XW;

  // stage valids and readies
  logic [3:0] v_r;
  logic [3:0] rdy;

  assign rdy[3]   = !v_r[3] || out_box.ready;
  assign rdy[2]   = !v_r[2] || rdy[3];
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  // stage 1: round to Q1.15, fold in quadrant
  logic signed [CSW-1:0] c_r, s_r, c_nxt, s_nxt;
  rrc_pkg::box_t         b1_r;
  logic signed [XW:0]    tx, ty;
  logic signed [CSW-1:0] cq, sq;

  always_comb begin
    tx = ($signed({in_data.x[XW-1], in_data.x}) + (XW+1)'(16384)) >>> 15;
    ty = ($signed({in_data.y[XW-1], in_data.y}) + (XW+1)'(16384)) >>> 15;
    if (tx > (XW+1)'(32768))       cq = CSW'(32768);
    else if (tx < -(XW+1)'(32768)) cq = -CSW'(32768);
    else                           cq = tx[CSW-1:0];
    if (ty > (XW+1)'(32768))       sq = CSW'(32768);
    else if (ty < -(XW+1)'(32768)) sq = -CSW'(32768);
    else                           sq = ty[CSW-1:0];
    if (in_data.box.fzero) begin
      cq = CSW'(32768);
      sq = '0;
    end
    case (in_data.box.quad)
      2'd1: begin
        c_nxt = -sq;
        s_nxt = cq;
      end
      2'd2: begin
        c_nxt = -cq;
        s_nxt = -sq;
      end
      2'd3: begin
        c_nxt = sq;
        s_nxt = -cq;
      end
      default: begin
        c_nxt = cq;
        s_nxt = sq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      c_r  <= c_nxt;
      s_r  <= s_nxt;
      b1_r <= in_data.box;
    end
  end

  // stage 2: four products
  logic signed [PW-1:0] a_r, b_r, cc_r, d_r;
  rrc_pkg::box_t        b2_r;
  logic signed [15:0]   ws, hs;

  assign ws = $signed({1'b0, b1_r.w});
  assign hs = $signed({1'b0, b1_r.h});

  always_ff @(posedge clk) begin
    if (rdy[1] && v_r[0]) begin
      a_r  <= ws * c_r;
      b_r  <= hs * s_r;
      cc_r <= ws * s_r;
      d_r  <= hs * c_r;
      b2_r <= b1_r;
    end
  end

  // stage 3: corner positions, centre added
  logic signed [VW-1:0] vx_r [4];
  logic signed [VW-1:0] vy_r [4];
  logic signed [VW-1:0] vx_nxt [4];
  logic signed [VW-1:0] vy_nxt [4];
  rrc_pkg::ord_t        ord3_r;
  logic signed [VW-1:0] ea, eb, ec, ed, ecx, ecy;

  always_comb begin
    ea  = VW'(a_r);
    eb  = VW'(b_r);
    ec  = VW'(cc_r);
    ed  = VW'(d_r);
    ecx = $signed({{(VW-32){b2_r.cx[15]}}, b2_r.cx, 16'h0000});
    ecy = $signed({{(VW-32){b2_r.cy[15]}}, b2_r.cy, 16'h0000});
    vx_nxt[0] = ecx - ea - eb;  vy_nxt[0] = ecy + ec - ed;
    vx_nxt[1] = ecx + ea - eb;  vy_nxt[1] = ecy - ec - ed;
    vx_nxt[2] = ecx + eb - ea;  vy_nxt[2] = ecy + ec + ed;
    vx_nxt[3] = ecx + ea + eb;  vy_nxt[3] = ecy + ed - ec;
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && v_r[1]) begin
      vx_r   <= vx_nxt;
      vy_r   <= vy_nxt;
      ord3_r <= b2_r.ord;
    end
  end

  // stage 4: ordering, rounding, saturation
  logic signed [15:0] rx [4];
  logic signed [15:0] ry [4];
  logic [3:0]         clx, cly;
  logic signed [VW:0] t;
  logic [1:0]         sel [4];
  logic [1:0]         xmin, xmax, ymin, ymax;
  logic signed [15:0] cor_x_r [4];
  logic signed [15:0] cor_y_r [4];
  logic signed [15:0] cor_x_nxt [4];
  logic signed [15:0] cor_y_nxt [4];
  logic               clip_r, clip_nxt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      t = ($signed({vx_r[k][VW-1], vx_r[k]}) + (VW+1)'(32768)) >>> 16;
      clx[k] = 1'b1;
      if (t > (VW+1)'(32767))        rx[k] = 16'sh7FFF;
      else if (t < -(VW+1)'(32768))  rx[k] = -16'sh8000;
      else begin
        rx[k]  = t[15:0];
        clx[k] = 1'b0;
      end
      t = ($signed({vy_r[k][VW-1], vy_r[k]}) + (VW+1)'(32768)) >>> 16;
      cly[k] = 1'b1;
      if (t > (VW+1)'(32767))        ry[k] = 16'sh7FFF;
      else if (t < -(VW+1)'(32768))  ry[k] = -16'sh8000;
      else begin
        ry[k]  = t[15:0];
        cly[k] = 1'b0;
      end
    end
    xmin = 2'd0; xmax = 2'd0; ymin = 2'd0; ymax = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (vx_r[k] > vx_r[xmax])      xmax = 2'(k);
      else if (vx_r[k] < vx_r[xmin]) xmin = 2'(k);
      if (vy_r[k] > vy_r[ymax])      ymax = 2'(k);
      else if (vy_r[k] < vy_r[ymin]) ymin = 2'(k);
    end
    case (ord3_r)
      rrc_pkg::ORD_IDENT: begin
        sel[0] = 2'd0; sel[1] = 2'd1; sel[2] = 2'd2; sel[3] = 2'd3;
      end
      rrc_pkg::ORD_CW: begin
        sel[0] = 2'd2; sel[1] = 2'd0; sel[2] = 2'd3; sel[3] = 2'd1;
      end
      rrc_pkg::ORD_HALF: begin
        sel[0] = 2'd3; sel[1] = 2'd2; sel[2] = 2'd1; sel[3] = 2'd0;
      end
      rrc_pkg::ORD_CCW: begin
        sel[0] = 2'd1; sel[1] = 2'd3; sel[2] = 2'd0; sel[3] = 2'd2;
      end
      default: begin
        sel[0] = xmin; sel[1] = ymin; sel[2] = ymax; sel[3] = xmax;
      end
    endcase
    clip_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      cor_x_nxt[k] = rx[sel[k]];
      cor_y_nxt[k] = ry[sel[k]];
      clip_nxt     = clip_nxt | clx[sel[k]] | cly[sel[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3] && v_r[2]) begin
      cor_x_r <= cor_x_nxt;
      cor_y_r <= cor_y_nxt;
      clip_r  <= clip_nxt;
    end
  end

  assign out_box.valid     = v_r[3];
  assign out_box.corner0_x = cor_x_r[0];
  assign out_box.corner0_y = cor_y_r[0];
  assign out_box.corner1_x = cor_x_r[1];
  assign out_box.corner1_y = cor_y_r[1];
  assign out_box.corner2_x = cor_x_r[2];
  assign out_box.corner2_y = cor_y_r[2];
  assign out_box.corner3_x = cor_x_r[3];
  assign out_box.corner3_y = cor_y_r[3];
  assign out_box.clipped   = clip_r;

endmodule

// ===== sv/rotated_rectangle_corners.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_rectangle_corners
// Four rotated corners of a box from size, angle and centre (Q12.4 screen).
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  in_box    in   box_width, box_height, rotation, center_x, center_y
//  out_box   out  corner0..3 x/y, clipped
//
//  One beat per cycle in and out while out_box.ready holds; the registers are
//  angle reduction, one register per CORDIC cell, then four post stages.
//  Every stage has its own valid and a local ready, so bubbles close up and
//  a stalled output only holds back stages that are full.
//  rst_n (synchronous) clears the stage valids only; no state between beats.
// ----------------------------------------------------------------------------
module rotated_rectangle_corners (
  input  logic       clk,
  input  logic       rst_n,
  rrc_in_if.sink     in_box,
  rrc_out_if.source  out_box
);

  localparam int N = rrc_pkg::CORDIC_STAGES;

  // ---- stage 0: reduce angle to quadrant + remainder, classify order ----
  logic signed [14:0] rw;
  logic signed [14:0] rr;
  logic [1:0]         quad;
  logic [10:0]        frac;
  rrc_pkg::ord_t      ord;
  rrc_pkg::cord_t     s0_nxt;
  rrc_pkg::cord_t     s0_r;
  logic               s0_v_r;

  logic               lk_v   [N+1];
  logic               lk_rdy [N+1];
  rrc_pkg::cord_t     lk_d   [N+1];

  always_comb begin
    rw = 15'(in_box.rotation);
    // wrap into [0, 5760)
    if (rw < -15'sd5760)      rr = rw + 15'sd11520;
    else if (rw < 15'sd0)     rr = rw + 15'sd5760;
    else if (rw >= 15'sd5760) rr = rw - 15'sd5760;
    else                      rr = rw;
    // quarter-turn split
    if (rr >= 15'sd4320) begin
      quad = 2'd3;
      frac = 11'(rr - 15'sd4320);
    end else if (rr >= 15'sd2880) begin
      quad = 2'd2;
      frac = 11'(rr - 15'sd2880);
    end else if (rr >= 15'sd1440) begin
      quad = 2'd1;
      frac = 11'(rr - 15'sd1440);
    end else begin
      quad = 2'd0;
      frac = 11'(rr);
    end
    // exact quarter turns from -270 to +270 degrees keep a fixed corner order
    if (in_box.rotation == rrc_pkg::ROT_ZERO)
      ord = rrc_pkg::ORD_IDENT;
    else if (in_box.rotation == rrc_pkg::ROT_M90 || in_box.rotation == rrc_pkg::ROT_P270)
      ord = rrc_pkg::ORD_CW;
    else if (in_box.rotation == rrc_pkg::ROT_M180 || in_box.rotation == rrc_pkg::ROT_P180)
      ord = rrc_pkg::ORD_HALF;
    else if (in_box.rotation == rrc_pkg::ROT_P90 || in_box.rotation == rrc_pkg::ROT_M270)
      ord = rrc_pkg::ORD_CCW;
    else
      ord = rrc_pkg::ORD_SORT;

    s0_nxt.x         = rrc_pkg::CORDIC_GAIN;
    s0_nxt.y         = '0;
    s0_nxt.z         = $signed({1'b0, frac, 16'h0000});
    s0_nxt.box.w     = in_box.box_width;
    s0_nxt.box.h     = in_box.box_height;
    s0_nxt.box.cx    = in_box.center_x;
    s0_nxt.box.cy    = in_box.center_y;
    s0_nxt.box.ord   = ord;
    s0_nxt.box.quad  = quad;
    s0_nxt.box.fzero = (frac == 11'd0);
  end

  assign in_box.ready = !s0_v_r || lk_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_box.ready) begin
      s0_v_r <= in_box.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_box.ready && in_box.valid) begin
      s0_r <= s0_nxt;
    end
  end

  // ---- CORDIC: a row of cells, one micro-rotation each ----
  assign lk_v[0] = s0_v_r;
  assign lk_d[0] = s0_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rrc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (rrc_pkg::IW'(i)),
      .in_valid  (lk_v[i]),
      .in_ready  (lk_rdy[i]),
      .in_data   (lk_d[i]),
      .out_valid (lk_v[i+1]),
      .out_ready (lk_rdy[i+1]),
      .out_data  (lk_d[i+1])
    );
  end

  // ---- trig finish, products, sums, ordering, output register ----
  rrc_corner u_corner (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (lk_v[N]),
    .in_ready (lk_rdy[N]),
    .in_data  (lk_d[N]),
    .out_box  (out_box)
  );

endmodule

// ===== sim/rotated_rectangle_corners_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_rectangle_corners_test
// Self-checking bench for the rotated rectangle corner block.
// ----------------------------------------------------------------------------
// Boxes are queued by an initial block and fed through the input channel by a
// clocked driver with random gaps. A clocked monitor takes the result beats
// under random back-pressure. Every accepted box is run through a local fixed
// point model (CORDIC, corner offsets, ordering, rounding and saturation), and
// its corners are queued. Each result beat is checked field by field against
// the oldest queued corners.
// ----------------------------------------------------------------------------
module rotated_rectangle_corners_test;

  localparam int  LIMIT_CYCLES = 200000;
  localparam int  TAIL_CYCLES  = rrc_pkg::CORDIC_STAGES + 20;
  localparam int  CALM_ITEMS   = 60;       // last boxes go through with no idling
  localparam longint GAIN_Q30  = 64'sd652032874;
  localparam longint TURN      = 5760;
  localparam longint QUARTER   = 1440;

  // atan(2^-i) in 2^-20 degree units
  localparam longint ATAN_DEG20 [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic               drain;   // hold this box until all results are back
    logic [14:0]        w;
    logic [14:0]        h;
    logic signed [13:0] rot;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
  } box_beat_t;

  typedef struct packed {
    logic [3:0][15:0] x;
    logic [3:0][15:0] y;
    logic             clip;
  } corners_t;

  logic clk;
  logic rst_n;

  rrc_in_if  in_box ();
  rrc_out_if out_box ();

  rotated_rectangle_corners dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_box  (in_box),
    .out_box (out_box)
  );

  box_beat_t pending_boxes[$];
  corners_t  expected_corners[$];
  int        errors;
  int        cycles;
  int        in_gap;
  int        out_gap;
  logic      took;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Model: quadrant-reduced CORDIC to Q1.15, then corner offsets in 2^-16 units
  // --------------------------------------------------------------------------
  function automatic longint q15_round(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint pos_round(longint v, inout logic clip);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 32767) begin
      clip = 1'b1;
      r = 32767;
    end else if (r < -32768) begin
      clip = 1'b1;
      r = -32768;
    end
    return r;
  endfunction

  function automatic corners_t predict_corners(box_beat_t b);
    corners_t res;
    longint rot, r, q, f, c0, s0, c, s, xr, yr, z, xs, ys;
    longint w, h, a, bb, cc, d, cxs, cys;
    longint vx[4];
    longint vy[4];
    int sel[4];
    int xmin, xmax, ymin, ymax;
    logic clip;
    rot = b.rot;
    r = rot % TURN;
    if (r < 0) r += TURN;
    q = r / QUARTER;
    f = r % QUARTER;
    if (f == 0) begin
      c0 = 32768;
      s0 = 0;
    end else begin
      xr = GAIN_Q30;
      yr = 0;
      z  = f * 65536;
      for (int i = 0; i < rrc_pkg::CORDIC_STAGES && i < 24; i++) begin
        xs = xr >>> i;
        ys = yr >>> i;
        if (z >= 0) begin
          xr -= ys; yr += xs; z -= ATAN_DEG20[i];
        end else begin
          xr += ys; yr -= xs; z += ATAN_DEG20[i];
        end
      end
      c0 = q15_round(xr);
      s0 = q15_round(yr);
    end
    case (q)
      1: begin c = -s0; s = c0;  end
      2: begin c = -c0; s = -s0; end
      3: begin c = s0;  s = -c0; end
      default: begin c = c0; s = s0; end
    endcase

    w = b.w;
    h = b.h;
    a = w * c; bb = h * s; cc = w * s; d = h * c;
    cxs = longint'(b.cx) * 65536;
    cys = longint'(b.cy) * 65536;
    // top-left, top-right, bottom-left, bottom-right
    vx[0] = cxs - (a + bb); vy[0] = cys + cc - d;
    vx[1] = cxs + a - bb;   vy[1] = cys - (cc + d);
    vx[2] = cxs + bb - a;   vy[2] = cys + cc + d;
    vx[3] = cxs + a + bb;   vy[3] = cys + d - cc;

    if (b.rot == rrc_pkg::ROT_ZERO) begin
      sel = '{0, 1, 2, 3};
    end else if (b.rot == rrc_pkg::ROT_M90 || b.rot == rrc_pkg::ROT_P270) begin
      sel = '{2, 0, 3, 1};
    end else if (b.rot == rrc_pkg::ROT_M180 || b.rot == rrc_pkg::ROT_P180) begin
      sel = '{3, 2, 1, 0};
    end else if (b.rot == rrc_pkg::ROT_P90 || b.rot == rrc_pkg::ROT_M270) begin
      sel = '{1, 3, 0, 2};
    end else begin
      // extremes on unrounded values; strict improvement so ties keep the earlier
      xmin = 0; xmax = 0; ymin = 0; ymax = 0;
      for (int k = 1; k < 4; k++) begin
        if (vx[k] > vx[xmax]) xmax = k;
        else if (vx[k] < vx[xmin]) xmin = k;
        if (vy[k] > vy[ymax]) ymax = k;
        else if (vy[k] < vy[ymin]) ymin = k;
      end
      sel = '{xmin, ymin, ymax, xmax};
    end

    clip = 1'b0;
    for (int k = 0; k < 4; k++) begin
      res.x[k] = 16'(pos_round(vx[sel[k]], clip));
      res.y[k] = 16'(pos_round(vy[sel[k]], clip));
    end
    res.clip = clip;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the head of the queue, random gap bursts between beats
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_box.valid <= 1'b0;
      out_box.ready <= 1'b0;
    end else begin
      if (!in_box.valid || took) begin
        if (in_gap > 0) begin
          in_box.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_boxes.size() > 0 &&
                     (!pending_boxes[0].drain || expected_corners.size() == 0)) begin
          in_box.valid      <= 1'b1;
          in_box.box_width  <= pending_boxes[0].w;
          in_box.box_height <= pending_boxes[0].h;
          in_box.rotation   <= pending_boxes[0].rot;
          in_box.center_x   <= pending_boxes[0].cx;
          in_box.center_y   <= pending_boxes[0].cy;
          if (pending_boxes.size() > CALM_ITEMS && $urandom_range(0, 5) == 0)
            in_gap <= $urandom_range(1, 4);
        end else begin
          in_box.valid <= 1'b0;
        end
      end
      // sink side: stall bursts, none near the end
      if (out_gap > 0) begin
        out_box.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_box.ready <= 1'b1;
        if (pending_boxes.size() > CALM_ITEMS && $urandom_range(0, 5) == 0)
          out_gap <= $urandom_range(1, 4);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on input beats, checks output beats, counts cycles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    corners_t got, exp_c;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end else begin
      took <= rst_n && in_box.valid && in_box.ready;
      if (rst_n && in_box.valid && in_box.ready) begin
        expected_corners = {expected_corners, predict_corners(pending_boxes[0])};
        void'(pending_boxes.pop_front());
      end
      if (rst_n && out_box.valid && out_box.ready) begin
        got.x = {out_box.corner3_x, out_box.corner2_x, out_box.corner1_x, out_box.corner0_x};
        got.y = {out_box.corner3_y, out_box.corner2_y, out_box.corner1_y, out_box.corner0_y};
        got.clip = out_box.clipped;
        if (expected_corners.size() == 0) begin
          $display("%0t: unexpected result beat, got %p", $time, got);
          errors++;
        end else begin
          exp_c = expected_corners.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got.x[k] !== exp_c.x[k]) begin
              $display("%0t: corner%0d_x expected %0d got %0d", $time, k,
                       $signed(exp_c.x[k]), $signed(got.x[k]));
              errors++;
            end
            if (got.y[k] !== exp_c.y[k]) begin
              $display("%0t: corner%0d_y expected %0d got %0d", $time, k,
                       $signed(exp_c.y[k]), $signed(got.y[k]));
              errors++;
            end
          end
          if (got.clip !== exp_c.clip) begin
            $display("%0t: clipped expected %0b got %0b", $time, exp_c.clip, got.clip);
            errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic box_beat_t mk_box(int w, int h, int rot, int cx, int cy, bit drain);
    box_beat_t b;
    b.drain = drain;
    b.w = 15'(w);
    b.h = 15'(h);
    b.rot = 14'(rot);
    b.cx = 16'(cx);
    b.cy = 16'(cy);
    return b;
  endfunction

  task automatic add_box(box_beat_t b);
    pending_boxes = {pending_boxes, b};
  endtask

  function automatic int pick_rotation();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return $urandom_range(0, 6) * 1440 - 4320;     // quarter turns
      1: return $urandom_range(0, 16) * 360 - 2880;     // 22.5 degree steps, ties
      2: return $urandom_range(0, 16383) - 8192;        // full field, wraps
      default: return $urandom_range(0, 11520) - 5760;
    endcase
  endfunction

  initial begin
    box_beat_t b;
    int wv, hv;
    rst_n = 1'b0;
    errors = 0;
    cycles = 0;
    in_gap = 0;
    out_gap = 0;
    took = 1'b0;
    in_box.valid = 1'b0;
    in_box.box_width = '0;
    in_box.box_height = '0;
    in_box.rotation = '0;
    in_box.center_x = '0;
    in_box.center_y = '0;
    out_box.ready = 1'b0;

    // Directed: fixed orders, degenerate boxes, field extremes, saturation, ties
    add_box(mk_box(160, 80, 0, 0, 0, 0));
    add_box(mk_box(160, 80, 1440, 100, -50, 0));
    add_box(mk_box(160, 80, -1440, 100, -50, 0));
    add_box(mk_box(160, 80, 2880, -300, 200, 0));
    add_box(mk_box(160, 80, -2880, -300, 200, 0));
    add_box(mk_box(160, 80, 4320, 7, 9, 0));
    add_box(mk_box(160, 80, -4320, 7, 9, 0));
    add_box(mk_box(160, 80, 5760, 7, 9, 0));
    add_box(mk_box(160, 80, -5760, 7, 9, 0));
    add_box(mk_box(0, 80, 480, 10, 10, 0));
    add_box(mk_box(160, 0, 480, 10, 10, 0));
    add_box(mk_box(0, 0, 123, 0, 0, 0));
    add_box(mk_box(32767, 32767, 0, 32767, 32767, 0));
    add_box(mk_box(32767, 32767, 720, -32768, -32768, 0));
    add_box(mk_box(32767, 1, 8191, 0, 0, 0));
    add_box(mk_box(1, 32767, -8192, 0, 0, 0));
    add_box(mk_box(400, 400, 720, 0, 0, 0));
    add_box(mk_box(400, 400, -720, 0, 0, 0));
    add_box(mk_box(20000, 300, 1, 32000, -32000, 0));
    add_box(mk_box(300, 20000, -1, -32000, 32000, 0));
    add_box(mk_box(5000, 3000, 7200, 1000, 1000, 0));
    add_box(mk_box(5000, 3000, -7200, 1000, 1000, 1));

    // Random boxes; a drain point part way through
    for (int i = 0; i < 450; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        wv = $urandom_range(0, 32767);
        hv = $urandom_range(0, 32767);
      end else begin
        wv = $urandom_range(0, 4095);
        hv = $urandom_range(0, 4095);
        if ($urandom_range(0, 7) == 0) hv = wv;          // squares tie on extremes
      end
      b = mk_box(wv, hv, pick_rotation(),
                 $urandom_range(0, 65535), $urandom_range(0, 65535), i == 200);
      add_box(b);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_boxes.size() > 0 || expected_corners.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== rotated_rectangle_corners.f =====
sv/rrc_pkg.sv
sv/rrc_in_if.sv
sv/rrc_out_if.sv
sv/rrc_cell.sv
sv/rrc_corner.sv
sv/rotated_rectangle_corners.sv
sim/rotated_rectangle_corners_test.sv
